/* src/bci_pkg.sv */
package bci_pkg;

   // operand width; fields on the ports stay 64 bits
   localparam int VALUE_WIDTH = 64;
   localparam int FIELD_WIDTH = 64;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MOD = 3'd4,
      OP_NEG = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_BOUNDS   = 2'd2,
      ST_DIVZERO  = 2'd3
   } status_type;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [VALUE_WIDTH-1:0]        mag_type;

   // sideband that rides along the divider pipe
   typedef struct packed {
      logic [2:0] op;
      value_type  res;
      status_type st;
      logic       q_neg;
      logic       r_neg;
      value_type  lo;
      value_type  hi;
   } tag_type;

endpackage

/* src/bci_req_if.sv */
interface bci_req_if;
   import bci_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [2:0]                    operation;
   logic signed [FIELD_WIDTH-1:0] operand_a;
   logic signed [FIELD_WIDTH-1:0] operand_b;
   logic signed [FIELD_WIDTH-1:0] bound_lo;
   logic signed [FIELD_WIDTH-1:0] bound_hi;

   modport source (output valid, operation, operand_a, operand_b, bound_lo,
                   bound_hi, input ready);
   modport sink   (input valid, operation, operand_a, operand_b, bound_lo,
                   bound_hi, output ready);
endinterface

/* src/bci_rsp_if.sv */
interface bci_rsp_if;
   import bci_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] result;
   logic [1:0]                    status;

   modport source (output valid, result, status, input ready);
   modport sink   (input valid, result, status, output ready);
endinterface

/* src/bci_div.sv */
module bci_div
   import bci_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  tag_type in_tag,
   input  mag_type dvd,
   input  mag_type dvs,
   output logic    out_valid,
   output tag_type out_tag,
   output mag_type quot,
   output mag_type rem
);

   localparam int W = VALUE_WIDTH;

   typedef struct packed {
      mag_type rem;
      mag_type dvd;
      mag_type quo;
   } step_type;

   // one restoring step: bring down the next dividend bit, try a subtract
   function automatic step_type div_step(mag_type r, mag_type d, mag_type q, mag_type s);
      logic [W:0] t;
      logic [W:0] diff;
      step_type   o;
      t        = {r, d[W-1]};
      diff     = t - {1'b0, s};
      o.dvd    = {d[W-2:0], 1'b0};
      if (!diff[W]) begin
         o.rem = diff[W-1:0];
         o.quo = {q[W-2:0], 1'b1};
      end else begin
         o.rem = t[W-1:0];
         o.quo = {q[W-2:0], 1'b0};
      end
      return o;
   endfunction

   mag_type  rem_ff [W];
   mag_type  dvd_ff [W];
   mag_type  quo_ff [W];
   mag_type  dvs_ff [W];
   tag_type  tag_ff [W];
   logic     vld_ff [W];
   step_type step_in [W];

   // one quotient bit per stage
   always_comb begin
      step_in[0] = div_step('0, dvd, '0, dvs);
      for (int j = 1; j < W; j++) begin
         step_in[j] = div_step(rem_ff[j-1], dvd_ff[j-1], quo_ff[j-1], dvs_ff[j-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < W; j++) vld_ff[j] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int j = 1; j < W; j++) vld_ff[j] <= vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < W; j++) begin
            rem_ff[j] <= step_in[j].rem;
            dvd_ff[j] <= step_in[j].dvd;
            quo_ff[j] <= step_in[j].quo;
         end
         dvs_ff[0] <= dvs;
         tag_ff[0] <= in_tag;
         for (int j = 1; j < W; j++) begin
            dvs_ff[j] <= dvs_ff[j-1];
            tag_ff[j] <= tag_ff[j-1];
         end
      end
   end

   assign out_valid = vld_ff[W-1];
   assign out_tag   = tag_ff[W-1];
   assign quot      = quo_ff[W-1];
   assign rem       = rem_ff[W-1];

endmodule

/* src/bounds_checked_integer_alu.sv */
// Channel  Dir  Payload                                             Transfer
// req      in   operation, operand_a/b, bound_lo, bound_hi          valid & ready
// rsp      out  result, status                                      valid & ready
//
// One item per cycle sustained while rsp does not stall; the divider pipe
// resolves one quotient bit per stage.
// Every item walks the whole pipe, so results leave in order.
// Synchronous active-high reset clears the valid bits only.
// A stalled rsp freezes all stages together; req.ready follows that stall.
module bounds_checked_integer_alu
   import bci_pkg::*;
(
   input logic     clock,
   input logic     reset,
   bci_req_if.sink req,
   bci_rsp_if.source rsp
);

   localparam int W  = VALUE_WIDTH;
   localparam int HL = (W + 1) / 2;
   localparam int HH = W - HL;

   typedef logic [2*W-1:0] prod_type;

   localparam mag_type   HALF   = mag_type'(1) << (W - 1);
   localparam value_type MINVAL = value_type'(HALF);

   logic advance;
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // stage 1: input register
   logic       v1_ff;
   logic [2:0] op1_ff;
   value_type  a1_ff, b1_ff, lo1_ff, hi1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req.valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op1_ff <= req.operation;
         a1_ff  <= req.operand_a[W-1:0];
         b1_ff  <= req.operand_b[W-1:0];
         lo1_ff <= req.bound_lo[W-1:0];
         hi1_ff <= req.bound_hi[W-1:0];
      end
   end

   // stage 2: add/sub/neg, divide checks, magnitudes
   tag_type    t2_in;
   logic [W:0] sum2, dif2;
   mag_type    ma2_in, mb2_in;

   always_comb begin
      sum2 = {a1_ff[W-1], a1_ff} + {b1_ff[W-1], b1_ff};
      dif2 = {a1_ff[W-1], a1_ff} - {b1_ff[W-1], b1_ff};
      ma2_in = a1_ff[W-1] ? mag_type'(-a1_ff) : mag_type'(a1_ff);
      mb2_in = b1_ff[W-1] ? mag_type'(-b1_ff) : mag_type'(b1_ff);
      t2_in.op    = op1_ff;
      t2_in.res   = '0;
      t2_in.st    = ST_OK;
      t2_in.q_neg = a1_ff[W-1] ^ b1_ff[W-1];
      t2_in.r_neg = a1_ff[W-1];
      t2_in.lo    = lo1_ff;
      t2_in.hi    = hi1_ff;
      case (op1_ff) inside
         OP_ADD: begin
            if (sum2[W] != sum2[W-1]) t2_in.st = ST_OVERFLOW;
            else t2_in.res = value_type'(sum2[W-1:0]);
         end
         OP_SUB: begin
            if (dif2[W] != dif2[W-1]) t2_in.st = ST_OVERFLOW;
            else t2_in.res = value_type'(dif2[W-1:0]);
         end
         OP_MUL: ;
         OP_DIV, OP_MOD: begin
            if (b1_ff == '0) t2_in.st = ST_DIVZERO;
            else if (a1_ff == MINVAL && b1_ff == '1) t2_in.st = ST_OVERFLOW;
         end
         OP_NEG: begin
            if (a1_ff == MINVAL) t2_in.st = ST_OVERFLOW;
            else t2_in.res = -a1_ff;
         end
         default: t2_in.st = ST_OVERFLOW;
      endcase
   end

   logic    v2_ff;
   tag_type t2_ff;
   mag_type ma2_ff, mb2_ff;

   // stage 3: partial products
   logic    v3_ff;
   tag_type t3_ff;
   mag_type ma3_ff, mb3_ff;
   logic [2*HL-1:0]  pll3_ff;
   logic [HL+HH-1:0] plh3_ff, phl3_ff;
   logic [2*HH-1:0]  phh3_ff;

   // stage 4: product sum
   logic     v4_ff;
   tag_type  t4_ff;
   mag_type  ma4_ff, mb4_ff;
   prod_type prod4_ff;
   prod_type prod4_in;

   assign prod4_in = prod_type'(pll3_ff)
                   + (prod_type'(plh3_ff) << HL)
                   + (prod_type'(phl3_ff) << HL)
                   + (prod_type'(phh3_ff) << (2 * HL));

   // stage 5: product range check
   tag_type t5_in;
   mag_type plo5, limit5;

   always_comb begin
      t5_in  = t4_ff;
      plo5   = prod4_ff[W-1:0];
      limit5 = t4_ff.q_neg ? HALF : HALF - mag_type'(1);
      if (t4_ff.op == OP_MUL) begin
         if (prod4_ff[2*W-1:W] != '0 || plo5 > limit5) t5_in.st = ST_OVERFLOW;
         else t5_in.res = t4_ff.q_neg ? value_type'(-plo5) : value_type'(plo5);
      end
   end

   logic    v5_ff;
   tag_type t5_ff;
   mag_type ma5_ff, mb5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t2_ff    <= t2_in;
         ma2_ff   <= ma2_in;
         mb2_ff   <= mb2_in;
         t3_ff    <= t2_ff;
         ma3_ff   <= ma2_ff;
         mb3_ff   <= mb2_ff;
         pll3_ff  <= ma2_ff[HL-1:0] * mb2_ff[HL-1:0];
         plh3_ff  <= ma2_ff[HL-1:0] * mb2_ff[W-1:HL];
         phl3_ff  <= ma2_ff[W-1:HL] * mb2_ff[HL-1:0];
         phh3_ff  <= ma2_ff[W-1:HL] * mb2_ff[W-1:HL];
         t4_ff    <= t3_ff;
         ma4_ff   <= ma3_ff;
         mb4_ff   <= mb3_ff;
         prod4_ff <= prod4_in;
         t5_ff    <= t5_in;
         ma5_ff   <= ma4_ff;
         mb5_ff   <= mb4_ff;
      end
   end

   // divider pipe
   logic    vd;
   tag_type td;
   mag_type quot, rem;

   bci_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v5_ff),
      .in_tag    (t5_ff),
      .dvd       (ma5_ff),
      .dvs       (mb5_ff),
      .out_valid (vd),
      .out_tag   (td),
      .quot      (quot),
      .rem       (rem)
   );

   // stage 6: sign fix of quotient or remainder
   tag_type t6_in, t6_ff;
   logic    v6_ff;

   always_comb begin
      t6_in = td;
      if (td.st == ST_OK) begin
         if (td.op == OP_DIV) t6_in.res = td.q_neg ? value_type'(-quot) : value_type'(quot);
         else if (td.op == OP_MOD) t6_in.res = td.r_neg ? value_type'(-rem) : value_type'(rem);
      end
   end

   // stage 7: bounds check into the output register
   status_type st7;
   value_type  res7;

   always_comb begin
      st7 = t6_ff.st;
      if (st7 == ST_OK && (t6_ff.res < t6_ff.lo || t6_ff.res > t6_ff.hi)) st7 = ST_BOUNDS;
      res7 = (st7 == ST_OK) ? t6_ff.res : '0;
   end

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v6_ff        <= vd;
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t6_ff      <= t6_in;
         rsp.result <= FIELD_WIDTH'(res7);
         rsp.status <= st7;
      end
   end

   assign rsp.valid = rsp_valid_ff;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
   import bci_pkg::*;

   typedef struct {
      logic signed [63:0] result;
      logic [1:0]         status;
   } outcome_type;

   localparam int LATENCY = VALUE_WIDTH + 7;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic signed [63:0] MIN_VAL = 64'sh8000000000000000;
   localparam logic signed [63:0] MAX_VAL = 64'sh7FFFFFFFFFFFFFFF;
   localparam logic signed [63:0] MINUS_ONE = -64'sd1;

   logic clock;
   logic reset;

   bci_req_if req ();
   bci_rsp_if rsp ();

   bounds_checked_integer_alu u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   outcome_type pending_outcomes[$];
   int          mismatch_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          idle_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predicted result for one operation
   function automatic outcome_type predict_alu(logic [2:0] op, logic signed [63:0] a,
                                               logic signed [63:0] b, logic signed [63:0] lo,
                                               logic signed [63:0] hi);
      outcome_type         o;
      logic signed [127:0] wide;
      o.result = '0;
      o.status = ST_OK;
      wide = '0;
      case (op) inside
         OP_ADD: wide = 128'(a) + 128'(b);
         OP_SUB: wide = 128'(a) - 128'(b);
         OP_MUL: wide = 128'(a) * 128'(b);
         OP_DIV, OP_MOD: begin
            if (b == 0) o.status = ST_DIVZERO;
            else if (a == MIN_VAL && b == MINUS_ONE) o.status = ST_OVERFLOW;
            else wide = 128'((op == OP_DIV) ? a / b : a % b);
         end
         OP_NEG: wide = -128'(a);
         default: o.status = ST_OVERFLOW;
      endcase
      if (o.status == ST_OK && (wide < 128'(MIN_VAL) || wide > 128'(MAX_VAL)))
         o.status = ST_OVERFLOW;
      if (o.status == ST_OK && (wide < 128'(lo) || wide > 128'(hi)))
         o.status = ST_BOUNDS;
      if (o.status == ST_OK) o.result = wide[63:0];
      return o;
   endfunction

   // send one operation; waits for the transfer, valid stays up for the next call
   task automatic send_op(logic [2:0] op, logic signed [63:0] a, logic signed [63:0] b,
                          logic signed [63:0] lo, logic signed [63:0] hi);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid     <= 1'b1;
      req.operation <= op;
      req.operand_a <= a;
      req.operand_b <= b;
      req.bound_lo  <= lo;
      req.bound_hi  <= hi;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending_outcomes.push_back(predict_alu(op, a, b, lo, hi));
      @(negedge clock);
   endtask

   function automatic logic signed [63:0] rand_value();
      logic signed [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(5))
         0: v = $signed(64'($urandom_range(20))) - 10;
         1: v = MIN_VAL + $urandom_range(3);
         2: v = MAX_VAL - $urandom_range(3);
         3: v = v >>> $urandom_range(63);
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_random_op();
      logic [2:0]         op;
      logic signed [63:0] a, b, lo, hi;
      op = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      a = rand_value();
      b = rand_value();
      // mostly wide-open bounds, sometimes tight or empty
      case ($urandom_range(3))
         0: begin lo = rand_value(); hi = rand_value(); end
         1: begin lo = -64'sd1000; hi = 64'sd1000; end
         default: begin lo = MIN_VAL; hi = MAX_VAL; end
      endcase
      send_op(op, a, b, lo, hi);
   endtask

   // response stall generator
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker and watchdog
   always @(posedge clock) begin
      outcome_type exp_o;
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result transfer");
            end else begin
               exp_o = pending_outcomes.pop_front();
               if (rsp.result !== exp_o.result || rsp.status !== exp_o.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp %0d/%0d got %0d/%0d", exp_o.result,
                              exp_o.status, rsp.result, rsp.status);
               end
            end
         end
      end
   end

   // stop sending and wait for every expected result
   task automatic drain_results();
      req.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
   endtask

   // directed corners
   task automatic test_corners();
      logic [2:0] op;
      send_op(OP_ADD, MAX_VAL, 64'sd1, MIN_VAL, MAX_VAL);
      send_op(OP_ADD, MIN_VAL, MINUS_ONE, MIN_VAL, MAX_VAL);
      send_op(OP_ADD, 64'sd5, 64'sd7, MIN_VAL, MAX_VAL);
      send_op(OP_SUB, MIN_VAL, 64'sd1, MIN_VAL, MAX_VAL);
      send_op(OP_SUB, MAX_VAL, MINUS_ONE, MIN_VAL, MAX_VAL);
      send_op(OP_SUB, 64'sd3, 64'sd10, MIN_VAL, MAX_VAL);
      send_op(OP_MUL, MIN_VAL, MINUS_ONE, MIN_VAL, MAX_VAL);
      send_op(OP_MUL, 64'sh4000000000000000, -64'sd2, MIN_VAL, MAX_VAL);
      send_op(OP_MUL, 64'sh100000000, 64'sh100000000, MIN_VAL, MAX_VAL);
      send_op(OP_MUL, -64'sd12, 64'sd11, MIN_VAL, MAX_VAL);
      send_op(OP_DIV, 64'sd7, 64'sd0, MIN_VAL, MAX_VAL);
      send_op(OP_DIV, MIN_VAL, MINUS_ONE, MIN_VAL, MAX_VAL);
      send_op(OP_DIV, -64'sd7, 64'sd2, MIN_VAL, MAX_VAL);
      send_op(OP_MOD, MIN_VAL, MINUS_ONE, MIN_VAL, MAX_VAL);
      send_op(OP_MOD, -64'sd7, 64'sd2, MIN_VAL, MAX_VAL);
      send_op(OP_MOD, 64'sd7, 64'sd0, MIN_VAL, MAX_VAL);
      send_op(OP_NEG, MIN_VAL, 64'sd0, MIN_VAL, MAX_VAL);
      send_op(OP_NEG, MAX_VAL, MAX_VAL, MIN_VAL, MAX_VAL);
      // empty and tight bound ranges
      send_op(OP_ADD, 64'sd1, 64'sd1, 64'sd5, -64'sd5);
      send_op(OP_ADD, 64'sd1, 64'sd1, 64'sd2, 64'sd2);
      send_op(OP_ADD, 64'sd1, 64'sd1, 64'sd3, 64'sd9);
      // undefined op codes
      op = 3'd6;
      send_op(op, 64'sd1, 64'sd1, MIN_VAL, MAX_VAL);
      op = 3'd7;
      send_op(op, MINUS_ONE, MINUS_ONE, MIN_VAL, MAX_VAL);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         send_random_op();
         // hold off once per phase until the pipe empties
         if (i == count / 2) drain_results();
      end
   endtask

   initial begin
      req.valid      = 1'b0;
      req.operation  = '0;
      req.operand_a  = '0;
      req.operand_b  = '0;
      req.bound_lo   = '0;
      req.bound_hi   = '0;
      rsp.ready      = 1'b0;
      mismatch_count = 0;
      idle_cycles    = 0;
      send_idle_pct  = 38;
      recv_idle_pct  = 50;
      reset          = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_corners();
      test_random(250);
      send_idle_pct = 50;
      recv_idle_pct = 38;
      test_random(250);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(250);

      drain_results();
      repeat (LATENCY + 10) @(negedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
